/* hw/rtl/wnse_pkg.sv */
// Shared constants and types of the neighbor sigma edge builder.
package wnse_pkg;

  localparam int unsigned MaxKDef      = 4;
  localparam int unsigned CoordBitsDef = 16;
  localparam int unsigned IdBitsDef    = 16;

  // Width and reset value of the k register.
  localparam int unsigned KW = 3;
  localparam logic [KW-1:0] KReset = 3'd4;

  // Per-item control word handed from the front to the engine.
  typedef struct packed {
    logic          last;
    logic [KW-1:0] kk;
  } wnse_ctl_t;

endpackage

/* hw/rtl/wnse_ram.sv */
// Generic single write port, single read port RAM with registered read.
module wnse_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 9
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/wnse_front.sv */
// Input side: accepts points, tags them with the clipped k, and queues them.
module wnse_front #(
  parameter int unsigned MAX_K      = 4,
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned ID_BITS    = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic signed [COORD_BITS-1:0]  x_coord_i,
  input  logic signed [COORD_BITS-1:0]  y_coord_i,
  input  logic signed [COORD_BITS-1:0]  z_coord_i,
  input  logic [ID_BITS-1:0]            point_id_i,
  input  logic                          last_point_i,
  input  logic [wnse_pkg::KW-1:0]       k_i,
  output logic                          item_valid_o,
  input  logic                          item_pop_i,
  output logic [3*COORD_BITS+ID_BITS-1:0] item_data_o,
  output wnse_pkg::wnse_ctl_t           item_ctl_o
);
  import wnse_pkg::*;

  localparam int unsigned ItemW = 3 * COORD_BITS + ID_BITS;

  logic [ItemW-1:0] data_q [2];
  wnse_ctl_t        ctl_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;
  wnse_ctl_t        ctl_in;

  always_comb begin
    ctl_in.last = last_point_i;
    ctl_in.kk   = (k_i > KW'(MAX_K)) ? KW'(MAX_K) : k_i;
  end

  assign full         = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign do_push      = push && !full;
  assign do_pop       = item_pop_i && item_valid_o;
  assign item_data_o  = data_q[rd_q];
  assign item_ctl_o   = ctl_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wr_q] <= {x_coord_i, y_coord_i, z_coord_i, point_id_i};
      ctl_q[wr_q]  <= ctl_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

/* hw/rtl/wnse_isqrt.sv */
// Iterative integer square root, two radicand bits per cycle.
module wnse_isqrt #(
  parameter int unsigned IN_W = 36
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [IN_W-1:0]     val_i,
  output logic                done_o,
  output logic [IN_W/2-1:0]   root_o
);

  localparam int unsigned Iter = IN_W / 2;
  localparam int unsigned CntW = $clog2(Iter + 1);

  logic [IN_W-1:0] v_q;
  logic [Iter:0]   rem_q;
  logic [Iter-1:0] root_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [Iter+2:0] rem_sh, trial, rem_nx;
  logic            ge;

  always_comb begin
    rem_sh = {rem_q, v_q[IN_W-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    ge     = (rem_sh >= trial);
    rem_nx = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q    <= val_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      v_q    <= {v_q[IN_W-3:0], 2'b00};
      rem_q  <= rem_nx[Iter:0];
      root_q <= {root_q[Iter-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(Iter - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* hw/rtl/wnse_div.sv */
// Restoring divider by a small count, one quotient bit per cycle.
module wnse_div #(
  parameter int unsigned NUM_W = 37,
  parameter int unsigned DEN_W = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] n_q;
  logic [DEN_W-1:0] r_q, d_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   r_sh, r_nx;
  logic             ge;

  always_comb begin
    r_sh = {r_q, n_q[NUM_W-1]};
    ge   = (r_sh >= {1'b0, d_q});
    r_nx = ge ? (r_sh - {1'b0, d_q}) : r_sh;
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= num_i;
      r_q <= '0;
      d_q <= den_i;
    end else if (busy_q) begin
      // The numerator shifts out on top while quotient bits enter below.
      n_q <= {n_q[NUM_W-2:0], ge};
      r_q <= r_nx[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = n_q;

endmodule

/* hw/rtl/wnse_engine.sv */
// Back end: point window, per-center distance statistics and edge output queue.
module wnse_engine #(
  parameter int unsigned MAX_K      = 4,
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned ID_BITS    = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            item_valid_i,
  output logic                            item_pop_o,
  input  logic [3*COORD_BITS+ID_BITS-1:0] item_data_i,
  input  wnse_pkg::wnse_ctl_t             item_ctl_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [ID_BITS-1:0]              neighbor_id_o,
  output logic [ID_BITS-1:0]              center_id_o,
  output logic                            last_edge_o
);
  import wnse_pkg::*;

  localparam int unsigned Depth  = 2 * MAX_K + 1;
  localparam int unsigned AW     = $clog2(Depth);
  localparam int unsigned PsW    = $clog2(Depth + 1);
  localparam int unsigned CwW    = $clog2(MAX_K + 2);
  localparam int unsigned CntW   = $clog2(2 * MAX_K + 1);
  localparam int unsigned MiW    = $clog2(2 * MAX_K);
  localparam int unsigned ItemW  = 3 * COORD_BITS + ID_BITS;
  localparam int unsigned DiffW  = COORD_BITS + 1;
  localparam int unsigned SqW    = 2 * DiffW;
  localparam int unsigned S3W    = SqW + 2;
  localparam int unsigned DistW  = S3W / 2;
  localparam int unsigned DsumW  = DistW + CntW;
  localparam int unsigned VsumW  = 2 * DistW + CntW;
  localparam int unsigned EdgeW  = 2 * ID_BITS + 1;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_SCHED = 13'b0000000000010,
    S_CRD   = 13'b0000000000100,
    S_CLAT  = 13'b0000000001000,
    S_NRD   = 13'b0000000010000,
    S_NLAT  = 13'b0000000100000,
    S_NSQ   = 13'b0000001000000,
    S_NSQRT = 13'b0000010000000,
    S_MDIV  = 13'b0000100000000,
    S_VAR   = 13'b0001000000000,
    S_VDIV  = 13'b0010000000000,
    S_TEST  = 13'b0100000000000,
    S_FIN   = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0]   wp_q, wp_d;
  logic [PsW-1:0]  ps_q, ps_d;
  logic [CwW-1:0]  cw_q, cw_d;
  logic [KW-1:0]   kk_q, kk_d;
  logic            last_q, last_d;
  logic [AW-1:0]   c_q, c_d;
  logic [CntW-1:0] nbb_q, nbb_d, cnt_q, cnt_d, m_q, m_d;
  logic [1:0]      axis_q, axis_d;
  logic [ItemW-1:0] ctr_q, ctr_d, nbr_q, nbr_d;
  logic [S3W-1:0]   s3_q, s3_d;
  logic [DsumW-1:0] sum_q, sum_d;
  logic [DistW-1:0] mean_q, mean_d;
  logic [VsumW-1:0] vsum_q, vsum_d, var_q, var_d;
  logic [DistW-1:0] dist_q [2*MAX_K];
  logic [ID_BITS-1:0] nid_q [2*MAX_K];
  logic               store_nb;
  logic [EdgeW-1:0]   pend_q, pend_d;
  logic               pend_v_q, pend_v_d;

  // Output queue.
  logic [EdgeW-1:0] oq_q [2];
  logic             oq_wr_q, oq_rd_q;
  logic [1:0]       oq_cnt_q;
  logic             oq_push, oq_pop, oq_full;
  logic [EdgeW-1:0] oq_din;

  // Window RAM.
  logic             ram_we;
  logic [AW-1:0]    ram_raddr, rd_idx;
  logic [ItemW-1:0] ram_rdata;

  // Arithmetic units.
  logic             sq_start, sq_done;
  logic [S3W-1:0]   sq_val;
  logic [DistW-1:0] sq_root;
  logic             dv_start, dv_done;
  logic [VsumW-1:0] dv_num, dv_quot;

  // Scheduling and datapath helpers.
  logic [7:0]       kk8, cw8, ps8, c8, behind8, nbb8, nbf8, m8, idx8;
  logic             serve;
  logic [AW+1:0]    a_t;
  logic signed [DiffW-1:0] ca, cb, diff;
  logic [DiffW-1:0] adiff;
  logic [SqW-1:0]   sq;
  logic [DistW-1:0] dm, dev;
  logic [2*DistW-1:0] dsq;
  logic [MiW-1:0]   mi;
  logic             m_last;

  wnse_ram #(
    .WIDTH(ItemW),
    .DEPTH(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wp_q),
    .wdata_i(item_data_i),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  wnse_isqrt #(
    .IN_W(S3W)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .val_i  (sq_val),
    .done_o (sq_done),
    .root_o (sq_root)
  );

  wnse_div #(
    .NUM_W(VsumW),
    .DEN_W(CntW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dv_start),
    .num_i  (dv_num),
    .den_i  (cnt_q),
    .done_o (dv_done),
    .quot_o (dv_quot)
  );

  // Which centers wait and how many neighbors the oldest one has on each side.
  always_comb begin
    kk8     = 8'(kk_q);
    cw8     = 8'(cw_q);
    ps8     = 8'(ps_q);
    c8      = cw8 - 8'd1;
    behind8 = ps8 - cw8;
    nbb8    = (kk8 < behind8) ? kk8 : behind8;
    nbf8    = (kk8 < c8) ? kk8 : c8;
    serve   = (cw8 > kk8) || (last_q && (cw_q != '0));
  end

  // Neighbor slot m: older points come first, nearest first, then newer ones.
  always_comb begin
    m8   = 8'(m_q);
    if (m_q < nbb_q) begin
      idx8 = 8'(c_q) + 8'd1 + m8;
    end else begin
      idx8 = 8'(c_q) - 8'd1 - (m8 - 8'(nbb_q));
    end
    rd_idx    = (state_q == S_CRD) ? c_q : AW'(idx8);
    // Window slot i lives i+1 places behind the write pointer.
    a_t       = {2'b00, wp_q} - (AW+2)'(1) - {2'b00, rd_idx};
    if (a_t[AW+1]) begin
      a_t = a_t + (AW+2)'(Depth);
    end
    ram_raddr = a_t[AW-1:0];
  end

  // One coordinate difference squared per cycle.
  always_comb begin
    case (axis_q)
      2'd0: begin
        ca = DiffW'(signed'(nbr_q[ItemW-1 -: COORD_BITS]));
        cb = DiffW'(signed'(ctr_q[ItemW-1 -: COORD_BITS]));
      end
      2'd1: begin
        ca = DiffW'(signed'(nbr_q[ItemW-COORD_BITS-1 -: COORD_BITS]));
        cb = DiffW'(signed'(ctr_q[ItemW-COORD_BITS-1 -: COORD_BITS]));
      end
      default: begin
        ca = DiffW'(signed'(nbr_q[ItemW-2*COORD_BITS-1 -: COORD_BITS]));
        cb = DiffW'(signed'(ctr_q[ItemW-2*COORD_BITS-1 -: COORD_BITS]));
      end
    endcase
    diff  = ca - cb;
    adiff = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
    sq    = SqW'(adiff) * SqW'(adiff);
  end

  // Squared deviation of distance m from the mean.
  always_comb begin
    mi     = m_q[MiW-1:0];
    dm     = dist_q[mi];
    dev    = (mean_q >= dm) ? (mean_q - dm) : (dm - mean_q);
    dsq    = (2*DistW)'(dev) * (2*DistW)'(dev);
    m_last = (m_q + CntW'(1) == cnt_q);
  end

  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    ps_d      = ps_q;
    cw_d      = cw_q;
    kk_d      = kk_q;
    last_d    = last_q;
    c_d       = c_q;
    nbb_d     = nbb_q;
    cnt_d     = cnt_q;
    m_d       = m_q;
    axis_d    = axis_q;
    ctr_d     = ctr_q;
    nbr_d     = nbr_q;
    s3_d      = s3_q;
    sum_d     = sum_q;
    mean_d    = mean_q;
    vsum_d    = vsum_q;
    var_d     = var_q;
    pend_d    = pend_q;
    pend_v_d  = pend_v_q;
    item_pop_o = 1'b0;
    ram_we    = 1'b0;
    sq_start  = 1'b0;
    sq_val    = s3_q + S3W'(sq);
    dv_start  = 1'b0;
    dv_num    = VsumW'(sum_q) + VsumW'(sq_root);
    store_nb  = 1'b0;
    oq_push   = 1'b0;
    oq_din    = {pend_q[EdgeW-1:1], 1'b0};

    case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          ram_we     = 1'b1;
          wp_d       = (wp_q == AW'(Depth - 1)) ? '0 : wp_q + AW'(1);
          if (ps_q < PsW'(Depth)) begin
            ps_d = ps_q + PsW'(1);
          end
          if (cw_q <= CwW'(MAX_K)) begin
            cw_d = cw_q + CwW'(1);
          end
          kk_d    = item_ctl_i.kk;
          last_d  = item_ctl_i.last;
          state_d = S_SCHED;
        end
      end
      S_SCHED: begin
        if (serve) begin
          c_d   = AW'(c8);
          nbb_d = CntW'(nbb8);
          cnt_d = CntW'(nbb8 + nbf8);
          if (nbb8 + nbf8 == 8'd0) begin
            // A center without neighbors leaves no edges.
            cw_d = cw_q - CwW'(1);
          end else begin
            state_d = S_CRD;
          end
        end else begin
          if (last_q) begin
            ps_d = '0;
          end
          state_d = S_FIN;
        end
      end
      S_CRD: begin
        state_d = S_CLAT;
      end
      S_CLAT: begin
        ctr_d   = ram_rdata;
        m_d     = '0;
        sum_d   = '0;
        state_d = S_NRD;
      end
      S_NRD: begin
        state_d = S_NLAT;
      end
      S_NLAT: begin
        nbr_d   = ram_rdata;
        axis_d  = 2'd0;
        s3_d    = '0;
        state_d = S_NSQ;
      end
      S_NSQ: begin
        s3_d = s3_q + S3W'(sq);
        if (axis_q == 2'd2) begin
          sq_start = 1'b1;
          state_d  = S_NSQRT;
        end else begin
          axis_d = axis_q + 2'd1;
        end
      end
      S_NSQRT: begin
        if (sq_done) begin
          store_nb = 1'b1;
          sum_d    = sum_q + DsumW'(sq_root);
          if (m_last) begin
            dv_start = 1'b1;
            m_d      = '0;
            state_d  = S_MDIV;
          end else begin
            m_d     = m_q + CntW'(1);
            state_d = S_NRD;
          end
        end
      end
      S_MDIV: begin
        if (dv_done) begin
          mean_d  = DistW'(dv_quot);
          vsum_d  = '0;
          m_d     = '0;
          state_d = S_VAR;
        end
      end
      S_VAR: begin
        vsum_d = vsum_q + VsumW'(dsq);
        dv_num = vsum_q + VsumW'(dsq);
        if (m_last) begin
          dv_start = 1'b1;
          m_d      = '0;
          state_d  = S_VDIV;
        end else begin
          m_d = m_q + CntW'(1);
        end
      end
      S_VDIV: begin
        if (dv_done) begin
          var_d   = dv_quot;
          m_d     = '0;
          state_d = S_TEST;
        end
      end
      S_TEST: begin
        if (m_q == cnt_q) begin
          cw_d    = cw_q - CwW'(1);
          state_d = S_SCHED;
        end else if (VsumW'(dsq) < var_q) begin
          // The previous edge leaves only once it is known not to be the last.
          if (!(pend_v_q && oq_full)) begin
            oq_push  = pend_v_q;
            pend_d   = {nid_q[mi], ctr_q[ID_BITS-1:0], 1'b0};
            pend_v_d = 1'b1;
            m_d      = m_q + CntW'(1);
          end
        end else begin
          m_d = m_q + CntW'(1);
        end
      end
      S_FIN: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (!oq_full) begin
          oq_push  = 1'b1;
          oq_din   = {pend_q[EdgeW-1:1], 1'b1};
          pend_v_d = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    c_q    <= c_d;
    nbb_q  <= nbb_d;
    cnt_q  <= cnt_d;
    m_q    <= m_d;
    axis_q <= axis_d;
    ctr_q  <= ctr_d;
    nbr_q  <= nbr_d;
    s3_q   <= s3_d;
    sum_q  <= sum_d;
    mean_q <= mean_d;
    vsum_q <= vsum_d;
    var_q  <= var_d;
    pend_q <= pend_d;
    kk_q   <= kk_d;
    last_q <= last_d;
    if (store_nb) begin
      dist_q[mi] <= sq_root;
      nid_q[mi]  <= nbr_q[ID_BITS-1:0];
    end
    if (oq_push) begin
      oq_q[oq_wr_q] <= oq_din;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      wp_q     <= '0;
      ps_q     <= '0;
      cw_q     <= '0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      wp_q     <= wp_d;
      ps_q     <= ps_d;
      cw_q     <= cw_d;
      pend_v_q <= pend_v_d;
    end
  end

  assign oq_full = (oq_cnt_q == 2'd2);
  assign empty   = (oq_cnt_q == 2'd0);
  assign oq_pop  = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= 2'd0;
    end else begin
      if (oq_push) begin
        oq_wr_q <= ~oq_wr_q;
      end
      if (oq_pop) begin
        oq_rd_q <= ~oq_rd_q;
      end
      if (oq_push && !oq_pop) begin
        oq_cnt_q <= oq_cnt_q + 2'd1;
      end else if (!oq_push && oq_pop) begin
        oq_cnt_q <= oq_cnt_q - 2'd1;
      end
    end
  end

  assign neighbor_id_o = oq_q[oq_rd_q][EdgeW-1 -: ID_BITS];
  assign center_id_o   = oq_q[oq_rd_q][ID_BITS:1];
  assign last_edge_o   = oq_q[oq_rd_q][0];

endmodule

/* hw/rtl/window_neighbor_sigma_edges_core.sv */
// Top level of the streaming neighbor sigma edge builder.
//
// Points enter in spatial order on a queue-style port: a word is taken when
// push is high and full is low. Edges leave the same way: the oldest edge sits
// on neighbor_id_o/center_id_o/last_edge_o while empty is low and is taken when
// pop is high. last_edge_o marks the final edge caused by one input point.
// The k register is written over cfg_valid_i/cfg_ready_o; ready is always high.
// The user must make writes only while the block is idle; no logic enforces it.
// A two-word input queue lets the next point arrive while the engine works.
// The engine handles one point at a time; each center it serves runs the
// iterative square root once per neighbor and the divider twice, for the
// mean and the variance of the neighbor distances. A closing point may
// serve up to MAX_K+1 centers.
// Reset empties both queues and the point window and sets k to 4.
// If the receiver stalls, the two-word output queue fills and the engine
// holds until an edge is taken; input then backs up through full.
module window_neighbor_sigma_edges_core #(
  parameter int unsigned MAX_K      = wnse_pkg::MaxKDef,
  parameter int unsigned COORD_BITS = wnse_pkg::CoordBitsDef,
  parameter int unsigned ID_BITS    = wnse_pkg::IdBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [wnse_pkg::KW-1:0]      cfg_k_i,
  input  logic                         push,
  output logic                         full,
  input  logic signed [COORD_BITS-1:0] x_coord_i,
  input  logic signed [COORD_BITS-1:0] y_coord_i,
  input  logic signed [COORD_BITS-1:0] z_coord_i,
  input  logic [ID_BITS-1:0]           point_id_i,
  input  logic                         last_point_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [ID_BITS-1:0]           neighbor_id_o,
  output logic [ID_BITS-1:0]           center_id_o,
  output logic                         last_edge_o
);
  import wnse_pkg::*;

  localparam int unsigned ItemW = 3 * COORD_BITS + ID_BITS;

  logic [KW-1:0]    k_q;
  logic             item_valid, item_pop;
  logic [ItemW-1:0] item_data;
  wnse_ctl_t        item_ctl;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= KReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      k_q <= cfg_k_i;
    end
  end

  wnse_front #(
    .MAX_K     (MAX_K),
    .COORD_BITS(COORD_BITS),
    .ID_BITS   (ID_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .x_coord_i   (x_coord_i),
    .y_coord_i   (y_coord_i),
    .z_coord_i   (z_coord_i),
    .point_id_i  (point_id_i),
    .last_point_i(last_point_i),
    .k_i         (k_q),
    .item_valid_o(item_valid),
    .item_pop_i  (item_pop),
    .item_data_o (item_data),
    .item_ctl_o  (item_ctl)
  );

  wnse_engine #(
    .MAX_K     (MAX_K),
    .COORD_BITS(COORD_BITS),
    .ID_BITS   (ID_BITS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .item_data_i  (item_data),
    .item_ctl_i   (item_ctl),
    .empty        (empty),
    .pop          (pop),
    .neighbor_id_o(neighbor_id_o),
    .center_id_o  (center_id_o),
    .last_edge_o  (last_edge_o)
  );

endmodule

/* hw/rtl/wnse_checker.sv */
// Port-level checks of the edge builder, bound to its top level.
module wnse_checker #(
  parameter int unsigned ID_BITS = wnse_pkg::IdBitsDef
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic [ID_BITS-1:0] neighbor_id_o,
  input logic [ID_BITS-1:0] center_id_o,
  input logic               last_edge_o
);

  // A waiting edge stays put until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(neighbor_id_o) &&
                          $stable(center_id_o) && $stable(last_edge_o)))
    else $error("output word changed while stalled");

  // Reset leaves both queues empty.
  a_reset_state: assert property (@(posedge clk_i)
    !rst_ni |-> (empty && !full))
    else $error("queues not empty under reset");

  // The input queue only fills up through an accepted word.
  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without an accepted word");

endmodule

bind window_neighbor_sigma_edges_core wnse_checker #(
  .ID_BITS(ID_BITS)
) u_wnse_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .push         (push),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .neighbor_id_o(neighbor_id_o),
  .center_id_o  (center_id_o),
  .last_edge_o  (last_edge_o)
);
